### hdl/bpa_pkg.sv
// shared types and constants for the bitmap page allocator
`default_nettype none
package bpa_pkg;
    localparam int MaxPages   = 4096;
    localparam int WordBits   = 8;
    localparam int PageW      = $clog2(MaxPages);
    localparam int CountW     = PageW + 1;
    localparam int Words      = MaxPages / WordBits;
    localparam int WordAddrW  = $clog2(Words);
    localparam int BitW       = $clog2(WordBits);
    localparam logic [WordBits-1:0] WordReset = 8'hFF;

    localparam logic [1:0] ActAlloc = 2'd0;
    localparam logic [1:0] ActFree  = 2'd1;
    localparam logic [1:0] ActAdd   = 2'd2;

    localparam logic CfgTotal  = 1'b0;
    localparam logic CfgEnable = 1'b1;
endpackage
`default_nettype wire

### hdl/bpa_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
`default_nettype none
module bpa_ram #(
    parameter int Width = 8,
    parameter int Depth = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/bitmap_page_allocator.sv
// bitmap page allocator top level: sequencer over one page bit at a time
//
// Input channel (i_valid/o_ready) carries action, page and count. Output
// channel (o_valid/i_ready) carries one result transaction per input.
// Configuration: i_cfg_we writes the page total (index 0) or enable (index 1);
// the user must do so only while the block is idle, which it does not enforce.
// After reset the block first sweeps all 512 words of the bitmap memory,
// setting every page used, with o_ready low.
// The bitmap sits in one 8-bit-wide RAM; the sequencer visits one page per
// step, and each step is a read and then a check or mark, any write of the
// bit falling in the check or mark state. Alloc first brings the rover below
// the page total by repeated subtraction, then scans pages, up to the managed
// total, for a free run of the count and marks each page of the run used;
// free and add visit each page of the range in turn. Refused items go
// straight from the start state to the result.
// The result register holds while the receiver stalls; o_ready stays low
// until it is taken, so one transaction is in the block at a time.
`default_nettype none
module bitmap_page_allocator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_index,
    input  wire logic [bpa_pkg::CountW-1:0] i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [1:0]                 i_action,
    input  wire logic [bpa_pkg::PageW-1:0]  i_page,
    input  wire logic [bpa_pkg::CountW-1:0] i_count,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic                            o_ok,
    output logic [bpa_pkg::PageW-1:0]       o_alloc_page,
    output logic [bpa_pkg::CountW-1:0]      o_free_cnt,
    output logic [bpa_pkg::CountW-1:0]      o_used_cnt,
    output logic [bpa_pkg::CountW-1:0]      o_skipped_pages
);
    localparam int PW = bpa_pkg::PageW;
    localparam int CW = bpa_pkg::CountW;
    localparam int AW = bpa_pkg::WordAddrW;
    localparam int BW = bpa_pkg::BitW;
    localparam int DW = bpa_pkg::WordBits;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_START  = 11'b00000000100,
        S_SREAD  = 11'b00000001000,
        S_SCHK   = 11'b00000010000,
        S_MREAD  = 11'b00000100000,
        S_MWRITE = 11'b00001000000,
        S_RREAD  = 11'b00010000000,
        S_RCHK   = 11'b00100000000,
        S_OUT    = 11'b01000000000,
        S_MOD    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_total, r_free, r_used, r_skip, r_count, r_i, r_streak;
    logic [PW-1:0] r_rover, r_idx, r_sstart, r_res_page;
    logic [PW-1:0] r_page;
    logic [1:0]    r_action;
    logic          r_enable, r_ok, r_fromalloc;
    logic [AW-1:0] r_clr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    bpa_ram #(.Width(DW), .Depth(bpa_pkg::Words)) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic [CW-1:0] mgd;
    assign mgd = (r_total > CW'(bpa_pkg::MaxPages)) ? CW'(bpa_pkg::MaxPages) : r_total;

    logic          bit_used;
    logic [BW-1:0] bsel;
    assign bsel     = r_idx[BW-1:0];
    assign bit_used = ram_rdata[bsel];

    logic [CW-1:0] idx_next_w;
    assign idx_next_w = {1'b0, r_idx} + CW'(1);

    logic [CW-1:0] idx_less_w;
    assign idx_less_w = {1'b0, r_idx} - mgd;

    // page of the release range, kept one bit wider so it never wraps
    logic [CW:0] rel_idx_w;
    logic        rel_clr;
    assign rel_idx_w = {2'b0, r_page} + {1'b0, r_i};
    assign rel_clr   = (rel_idx_w < {1'b0, mgd}) && bit_used;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[PW-1:BW];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[PW-1:BW];
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = bpa_pkg::WordReset;
        end else if (r_state == S_MWRITE) begin
            ram_we          = 1'b1;
            ram_wdata[bsel] = 1'b1;
        end else if (r_state == S_RCHK && rel_clr) begin
            ram_we          = 1'b1;
            ram_wdata[bsel] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_total  <= CW'(bpa_pkg::MaxPages);
            r_enable <= 1'b0;
            r_rover  <= '0;
            r_free   <= '0;
            r_used   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == bpa_pkg::CfgTotal) r_total <= i_cfg_data;
                else r_enable <= i_cfg_data[0];
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(bpa_pkg::Words - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_action <= i_action;
                        r_page   <= i_page;
                        r_count  <= i_count;
                        r_ok     <= 1'b0;
                        r_skip   <= '0;
                        r_res_page <= '0;
                        r_state  <= S_START;
                    end
                end
                S_START: begin
                    r_i      <= '0;
                    r_streak <= '0;
                    r_idx    <= r_page;
                    r_state  <= S_OUT;
                    if (r_count != '0) begin
                        if (r_action == bpa_pkg::ActAlloc && r_enable) begin
                            if (mgd != '0 && r_count <= mgd) begin
                                r_idx   <= r_rover;
                                r_state <= S_MOD;
                            end
                        end else if ((r_action == bpa_pkg::ActFree && r_enable) ||
                                     r_action == bpa_pkg::ActAdd) begin
                            r_fromalloc <= (r_action == bpa_pkg::ActFree);
                            r_ok        <= 1'b1;
                            r_state     <= S_RREAD;
                        end
                    end
                end
                S_MOD: begin
                    if ({1'b0, r_idx} >= mgd) r_idx <= idx_less_w[PW-1:0];
                    else r_state <= S_SREAD;
                end
                S_SREAD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (bit_used) begin
                        r_streak <= '0;
                    end else begin
                        if (r_streak == '0 || r_idx == '0) r_sstart <= r_idx;
                        r_streak <= ((r_idx == '0) ? CW'(0) : r_streak) + CW'(1);
                    end
                    if (!bit_used &&
                        ((r_idx == '0) ? CW'(1) : r_streak + CW'(1)) == r_count) begin
                        r_ok    <= 1'b1;
                        r_res_page <= (r_streak == '0 || r_idx == '0) ? r_idx : r_sstart;
                        r_idx   <= (r_streak == '0 || r_idx == '0) ? r_idx : r_sstart;
                        r_i     <= '0;
                        r_state <= S_MREAD;
                    end else if (r_i + CW'(1) == mgd) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_idx   <= (idx_next_w == mgd) ? '0 : idx_next_w[PW-1:0];
                        r_state <= S_SREAD;
                    end
                end
                S_MREAD: r_state <= S_MWRITE;
                S_MWRITE: begin
                    r_idx <= idx_next_w[PW-1:0];
                    r_i   <= r_i + CW'(1);
                    if (r_i + CW'(1) == r_count) begin
                        r_rover <= (idx_next_w == mgd) ? '0 : idx_next_w[PW-1:0];
                        r_free  <= r_free - r_count;
                        r_used  <= r_used + r_count;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MREAD;
                    end
                end
                S_RREAD: r_state <= S_RCHK;
                S_RCHK: begin
                    if (!rel_clr) begin
                        r_skip <= r_skip + CW'(1);
                    end else begin
                        r_free <= r_free + CW'(1);
                        if (r_fromalloc && r_used != '0) r_used <= r_used - CW'(1);
                    end
                    r_i   <= r_i + CW'(1);
                    r_idx <= idx_next_w[PW-1:0];
                    if (r_i + CW'(1) == r_count) r_state <= S_OUT;
                    else r_state <= S_RREAD;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_ok            = r_ok;
    assign o_alloc_page    = r_res_page;
    assign o_free_cnt      = r_free;
    assign o_used_cnt      = r_used;
    assign o_skipped_pages = r_skip;
endmodule
`default_nettype wire

### hdl/bpa_checker.sv
// port-level assertions for the bitmap page allocator
`default_nettype none
module bpa_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_ready,
    input wire logic                       o_valid,
    input wire logic                       i_ready,
    input wire logic                       o_ok,
    input wire logic [bpa_pkg::PageW-1:0]  o_alloc_page,
    input wire logic [bpa_pkg::CountW-1:0] o_skipped_pages
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_alloc_page))
        else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("took two items");
    a_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_alloc_page == '0) else $error("page on failure");
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_skipped_pages == '0) else $error("skips on failure");
endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_ok(o_ok),
    .o_alloc_page(o_alloc_page), .o_skipped_pages(o_skipped_pages)
);
`default_nettype wire
